// ----- rtl/hufd_pkg.sv -----
`timescale 1ns / 1ps

package hufd_pkg;

   localparam int NODE_W      = 9;
   localparam int SYM_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 32;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int BIT_CNT_W   = 3;

   localparam int DEF_MAX_NODES  = 512;
   localparam int DEF_MAX_LEAVES = 256;

   localparam logic [NODE_W-1:0] LEAF_COUNT_RST = NODE_W'(2);
   localparam logic [NODE_W-1:0] LEAF_COUNT_MIN = NODE_W'(2);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_DECODE  = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEAF_COUNT    = 1'd0,
      CSR_TOTAL_SYMBOLS = 1'd1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EVAL,
      ST_SYM,
      ST_FLUSH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // write one tree node
      logic decode_start; // capture code byte
      logic restart;      // walk back to root, clear count
      logic node_read;    // read children of current node
      logic node_step;    // move to inner child, next bit
      logic sym_read;     // read symbol of leaf child
      logic sym_commit;   // take symbol into pending slot
      logic stop;         // symbol count reached
      logic flush;        // push pending as last of byte
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic stop;
      logic is_leaf;
      logic last_bit;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/hufd_ram.sv -----
`timescale 1ns / 1ps

module hufd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/hufd_ctrl.sv -----
`timescale 1ns / 1ps

module hufd_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [hufd_pkg::OP_W-1:0]       req_operation,
   output logic                            req_stall,
   input  hufd_pkg::sts_type               sts,
   output hufd_pkg::cmd_type               cmd
);
   import hufd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (op_type'(req_operation))
                  OP_LOAD:    cmd.load = 1'b1;
                  OP_RESTART: cmd.restart = 1'b1;
                  OP_DECODE: begin
                     cmd.decode_start = 1'b1;
                     state_in         = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (sts.stop) begin
               cmd.stop = 1'b1;
               state_in = ST_FLUSH;
            end else begin
               cmd.node_read = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.is_leaf) begin
               cmd.sym_read = 1'b1;
               state_in     = ST_SYM;
            end else begin
               cmd.node_step = 1'b1;
               state_in      = sts.last_bit ? ST_FLUSH : ST_CHECK;
            end
         end
         ST_SYM: begin
            // older pending symbol must have room in the output register
            if (!sts.pend_valid || sts.out_free) begin
               cmd.sym_commit = 1'b1;
               state_in       = sts.last_bit ? ST_FLUSH : ST_CHECK;
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid || sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/hufd_dpath.sv -----
`timescale 1ns / 1ps

module hufd_dpath #(
   parameter int MAX_NODES  = hufd_pkg::DEF_MAX_NODES,
   parameter int MAX_LEAVES = hufd_pkg::DEF_MAX_LEAVES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [hufd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hufd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [hufd_pkg::NODE_W-1:0]       req_node_index,
   input  logic [hufd_pkg::NODE_W-1:0]       req_left_child,
   input  logic [hufd_pkg::NODE_W-1:0]       req_right_child,
   input  logic [hufd_pkg::SYM_W-1:0]        req_leaf_symbol,
   input  logic [hufd_pkg::BYTE_W-1:0]       req_code_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hufd_pkg::SYM_W-1:0]        rsp_symbol,
   output logic                              rsp_last_of_byte,
   output logic                              rsp_stream_done,
   input  hufd_pkg::cmd_type                 cmd,
   output hufd_pkg::sts_type                 sts
);
   import hufd_pkg::*;

   localparam int NAW = $clog2(MAX_NODES);
   localparam int LAW = $clog2(MAX_LEAVES);
   localparam logic [NODE_W:0]   NODES_LIM  = (NODE_W+1)'(MAX_NODES);
   localparam logic [NODE_W-1:0] LEAVES_LIM = NODE_W'(MAX_LEAVES);

   // configuration
   logic [NODE_W-1:0] leaf_count_ff;
   logic [CNT_W-1:0]  total_ff;

   // walk state
   logic [NODE_W-1:0]    node_ff;
   logic                 at_root_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 finished_ff;
   logic [BYTE_W-1:0]    bits_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;
   logic                 oor_ff;

   // pending symbol and output register
   logic              pend_valid_ff;
   logic [SYM_W-1:0]  pend_sym_ff;
   logic              pend_done_ff;
   logic              out_valid_ff;
   logic [SYM_W-1:0]  out_sym_ff;
   logic              out_last_ff;
   logic              out_done_ff;

   logic [NODE_W-1:0] eff_lc;
   logic [NODE_W-1:0] root;
   logic [NODE_W-1:0] cur_node;
   logic [NODE_W-1:0] left_rd;
   logic [NODE_W-1:0] right_rd;
   logic [NODE_W-1:0] next_node;
   logic [SYM_W-1:0]  sym_rd;
   logic [CNT_W-1:0]  count_inc;
   logic              hit_total;
   logic              node_we;
   logic              sym_we;
   logic              out_load;
   logic              out_take;

   always_comb begin
      if (leaf_count_ff < LEAF_COUNT_MIN) begin
         eff_lc = LEAF_COUNT_MIN;
      end else if (leaf_count_ff > LEAVES_LIM) begin
         eff_lc = LEAVES_LIM;
      end else begin
         eff_lc = leaf_count_ff;
      end
   end

   assign root      = NODE_W'({eff_lc, 1'b0} - (NODE_W+1)'(2));
   assign cur_node  = at_root_ff ? root : node_ff;
   assign next_node = oor_ff ? '0 : (bits_ff[BYTE_W-1] ? right_rd : left_rd);
   assign count_inc = count_ff + CNT_W'(1);
   assign hit_total = (count_inc == total_ff);

   assign node_we = cmd.load && ({1'b0, req_node_index} < NODES_LIM);
   assign sym_we  = cmd.load && (req_node_index < LEAVES_LIM);

   hufd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_left_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (req_node_index[NAW-1:0]),
      .wdata (req_left_child),
      .re    (cmd.node_read),
      .raddr (cur_node[NAW-1:0]),
      .rdata (left_rd)
   );

   hufd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_right_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (req_node_index[NAW-1:0]),
      .wdata (req_right_child),
      .re    (cmd.node_read),
      .raddr (cur_node[NAW-1:0]),
      .rdata (right_rd)
   );

   hufd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEAVES)) u_sym_ram (
      .clock (clock),
      .we    (sym_we),
      .waddr (req_node_index[LAW-1:0]),
      .wdata (req_leaf_symbol),
      .re    (cmd.sym_read),
      .raddr (next_node[LAW-1:0]),
      .rdata (sym_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LEAF_COUNT_RST;
         total_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LEAF_COUNT:    leaf_count_ff <= csr_wdata[NODE_W-1:0];
            CSR_TOTAL_SYMBOLS: total_ff      <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff     <= '0;
         at_root_ff  <= 1'b1;
         count_ff    <= '0;
         finished_ff <= 1'b0;
      end else begin
         if (cmd.restart) begin
            node_ff     <= '0;
            at_root_ff  <= 1'b1;
            count_ff    <= '0;
            finished_ff <= 1'b0;
         end
         if (cmd.stop) begin
            finished_ff <= 1'b1;
         end
         if (cmd.node_step) begin
            node_ff    <= next_node;
            at_root_ff <= 1'b0;
         end
         if (cmd.sym_commit) begin
            node_ff    <= root;
            at_root_ff <= 1'b1;
            count_ff   <= count_inc;
            if (hit_total) begin
               finished_ff <= 1'b1;
            end
         end
      end
   end

   // bit walk over the code byte, MSB first
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
      end else if (cmd.decode_start) begin
         bit_cnt_ff <= '0;
      end else if (cmd.node_step || cmd.sym_commit) begin
         bit_cnt_ff <= bit_cnt_ff + BIT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode_start) begin
         bits_ff <= req_code_byte;
      end else if (cmd.node_step || cmd.sym_commit) begin
         bits_ff <= {bits_ff[BYTE_W-2:0], 1'b0};
      end
      if (cmd.node_read) begin
         oor_ff <= ({1'b0, cur_node} >= NODES_LIM);
      end
   end

   // one symbol held back until it is known whether it ends the byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.sym_commit) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sym_commit) begin
         pend_sym_ff  <= sym_rd;
         pend_done_ff <= hit_total;
      end
   end

   assign out_take = out_valid_ff && !rsp_stall;
   assign out_load = (cmd.sym_commit || cmd.flush) && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sym_ff  <= pend_sym_ff;
         out_last_ff <= cmd.flush;
         out_done_ff <= pend_done_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_symbol       = out_sym_ff;
   assign rsp_last_of_byte = out_last_ff;
   assign rsp_stream_done  = out_done_ff;

   assign sts.stop       = finished_ff || (count_ff >= total_ff);
   assign sts.is_leaf    = (next_node < eff_lc);
   assign sts.last_bit   = (bit_cnt_ff == BIT_CNT_W'(BYTE_W - 1));
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

endmodule

// ----- rtl/huffman_tree_walk_decoder.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_stall  operation, node, children, symbol, code byte
// rsp_*     out        rsp_valid / rsp_stall  symbol, last_of_byte, stream_done
// csr_*     in         csr_write              csr_index, csr_wdata
//
// Load, restart and unused items complete on acceptance. A code byte is accepted, then
// each inner-node bit passes check (stop check and node memory read) and eval (child
// select), each leaf bit adds the symbol memory read and the sym state, and a closing
// flush state ends the byte; once the symbol count is reached, check goes to flush.
// Reset is synchronous and active high; tree memories are not cleared.
// A stalled rsp side holds the walk only when a second symbol needs the output.

module huffman_tree_walk_decoder #(
   parameter int MAX_NODES  = hufd_pkg::DEF_MAX_NODES,
   parameter int MAX_LEAVES = hufd_pkg::DEF_MAX_LEAVES
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write,
   input  logic [hufd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hufd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hufd_pkg::OP_W-1:0]         req_operation,
   input  logic [hufd_pkg::NODE_W-1:0]       req_node_index,
   input  logic [hufd_pkg::NODE_W-1:0]       req_left_child,
   input  logic [hufd_pkg::NODE_W-1:0]       req_right_child,
   input  logic [hufd_pkg::SYM_W-1:0]        req_leaf_symbol,
   input  logic [hufd_pkg::BYTE_W-1:0]       req_code_byte,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hufd_pkg::SYM_W-1:0]        rsp_symbol,
   output logic                              rsp_last_of_byte,
   output logic                              rsp_stream_done
);
   import hufd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: one tree step per pass through check / eval (/ sym)
   hufd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   // tree memories, walk registers, pending slot and output register
   hufd_dpath #(
      .MAX_NODES  (MAX_NODES),
      .MAX_LEAVES (MAX_LEAVES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_node_index   (req_node_index),
      .req_left_child   (req_left_child),
      .req_right_child  (req_right_child),
      .req_leaf_symbol  (req_leaf_symbol),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_stream_done  (rsp_stream_done),
      .cmd              (cmd),
      .sts              (sts)
   );

`ifndef SYNTHESIS
   // a decode item occupies the block for at least the next cycle
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_DECODE) |=> req_stall)
      else $error("decode item accepted but input not stalled");

   // a pending symbol never overwrites an unaccepted result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.sym_commit || cmd.flush) && sts.pend_valid |-> sts.out_free)
      else $error("output register overwritten");

   // no symbol is taken once the count is reached
   a_no_extra_sym: assert property (@(posedge clock) disable iff (reset)
      cmd.sym_commit |-> !sts.stop)
      else $error("symbol emitted past total count");

   // the byte closes with nothing left pending
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !sts.pend_valid)
      else $error("pending symbol left after byte end");
`endif

endmodule
